// File: hdl/lms_ale_pkg.sv
// Shared constants for the LMS adaptive line enhancer.
// Field widths, fixed-point scaling and configuration register indexes.
// No dependencies.
package lms_ale_pkg;

    // field and datapath widths
    localparam int SAMPLE_W   = 16;   // Q1.15 samples
    localparam int COEF_W     = 32;   // Q5.27 coefficients
    localparam int STEP_W     = 16;   // Q0.16 step size
    localparam int ORDER_W    = 9;
    localparam int DELAY_W    = 8;
    localparam int GAIN_W     = 32;   // step*error, Q1.31
    localparam int PROD_W     = COEF_W + SAMPLE_W;

    // fixed-point shifts
    localparam int COEF_FRAC  = 27;   // Q6.42 product sum back to Q1.15
    localparam int UPD_SHIFT  = 19;   // Q2.46 update back to Q5.27

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd3;

    localparam logic [ORDER_W-1:0] ORDER_RST = 9'd16;
    localparam logic [DELAY_W-1:0] DELAY_RST = 8'd1;
    localparam logic [STEP_W-1:0]  STEP_RST  = 16'd328;

    localparam logic MODE_PREDICT = 1'b0;  // noise cancel: output prediction
    localparam logic MODE_ERROR   = 1'b1;  // tone cancel: output error

endpackage

// File: hdl/lms_adaptive_line_enhancer.sv
// LMS adaptive line enhancer, top level.
// Sequencer around one shared 32x16 multiplier, history and coefficient memories.
// Depends on lms_ale_pkg.
//
//  channel   signals                               direction  transaction when
//  --------  ------------------------------------  ---------  ----------------------
//  input     i_valid, o_stall, i_sample            in         i_valid && !o_stall
//  output    o_valid, i_stall, o_result_sample     out        o_valid && !i_stall
//  config    i_cfg_valid, o_cfg_ready,             in         i_cfg_valid && o_cfg_ready
//            i_cfg_index, i_cfg_data
//
//  A sample keeps o_stall high from its transaction until the sequencer is back in
//  S_IDLE: one multiplier step per tap (taps = order, capped at MAX_TAPS) for the
//  prediction pass, another for the update pass. After reset a sweep over all
//  MAX_TAPS entries zeroes the coefficient memory with o_stall high; config writes
//  are taken throughout. History entries never written read as zero through a fill
//  count. The result sits in an output register, so a new sample is taken while
//  o_valid waits on i_stall; that one then holds in S_OUT until it goes.
module lms_adaptive_line_enhancer #(
    parameter int MAX_TAPS  = 256,
    parameter int MAX_DELAY = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // sample input
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic signed [lms_ale_pkg::SAMPLE_W-1:0]  i_sample,
    // result output
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic signed [lms_ale_pkg::SAMPLE_W-1:0]  o_result_sample,
    // configuration writes
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [lms_ale_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lms_ale_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int SW       = lms_ale_pkg::SAMPLE_W;
    localparam int CW       = lms_ale_pkg::COEF_W;
    localparam int PRW      = lms_ale_pkg::PROD_W;
    localparam int GW       = lms_ale_pkg::GAIN_W;
    localparam int HIST_LEN = MAX_TAPS + MAX_DELAY;
    localparam int HIST_W   = $clog2(HIST_LEN);
    localparam int TAP_CW   = $clog2(MAX_TAPS + 1);              // holds 0..MAX_TAPS
    localparam int TAP_AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int ACC_W    = PRW + TAP_CW;
    localparam int OW       = lms_ale_pkg::ORDER_W;
    localparam int TW       = (OW > TAP_CW) ? OW : TAP_CW;
    localparam int DW       = lms_ale_pkg::DELAY_W;
    localparam int PW       = ((DW > HIST_W) ? DW : HIST_W) + 2;  // signed position math

    localparam logic [TW-1:0]           C_TAPS_MAX  = TW'(MAX_TAPS);
    localparam logic [PW-1:0]           C_DLY_LIM   = PW'(MAX_DELAY);
    localparam logic [PW-1:0]           C_DLY_MAX   = PW'(MAX_DELAY - 1);
    localparam logic [PW-1:0]           C_HIST_LEN  = PW'(HIST_LEN);
    localparam logic [HIST_W-1:0]       C_HIST_LAST = HIST_W'(HIST_LEN - 1);
    localparam logic [TAP_AW-1:0]       C_TAP_LAST  = TAP_AW'(MAX_TAPS - 1);
    localparam logic signed [ACC_W-1:0] C_ACC_HALF  = ACC_W'(2 ** (lms_ale_pkg::COEF_FRAC - 1));
    localparam logic signed [ACC_W-1:0] C_ACC_MAX   = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] C_ACC_MIN   = ACC_W'(-32768);
    localparam logic signed [PRW-1:0]   C_UPD_HALF  = PRW'(2 ** (lms_ale_pkg::UPD_SHIFT - 1));
    localparam logic signed [SW:0]      C_E_MAX     = (SW + 1)'(32767);
    localparam logic signed [SW:0]      C_E_MIN     = (SW + 1)'(-32768);
    localparam logic signed [CW:0]      C_COEF_MAX  = (CW + 1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [CW:0]      C_COEF_MIN  = -((CW + 1)'(64'sd1 <<< (CW - 1)));

    typedef enum logic [3:0] {
        S_CLEAR,     // zero the coefficient memory after reset
        S_IDLE,
        S_MAC,       // prediction pass: issue one tap per cycle
        S_MAC_WAIT,  // let the pipe drain into the accumulator
        S_PRED,      // round and saturate the prediction
        S_ERR,       // form the saturated error
        S_GAIN,      // step * error through the multiplier
        S_GAIN_LD,
        S_UPD,       // update pass: issue one tap per cycle
        S_UPD_WAIT,
        S_OUT        // hand the result to the output register
    } t_state;

    // configuration registers
    logic [OW-1:0]                     r_order;
    logic [DW-1:0]                     r_delay;
    logic [lms_ale_pkg::STEP_W-1:0]    r_step;
    logic                              r_mode;

    // memories
    logic signed [SW-1:0] mem_hist [HIST_LEN];
    logic signed [CW-1:0] mem_coef [MAX_TAPS];
    logic signed [SW-1:0] r_hist_rd;
    logic signed [CW-1:0] r_coef_rd;

    // sequencer and per-sample state
    t_state               r_state;
    logic [TAP_AW-1:0]    r_clr;
    logic [HIST_W-1:0]    r_wi;
    logic [HIST_W-1:0]    r_fill;
    logic [TAP_CW-1:0]    r_taps;
    logic [TAP_CW-1:0]    r_k;
    logic [HIST_W-1:0]    r_base;
    logic [HIST_W-1:0]    r_pos;
    logic [PW-1:0]        r_dist0;
    logic [PW-1:0]        r_dist;
    logic                 r_upd;
    logic signed [SW-1:0] r_x;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [SW-1:0] r_y;
    logic signed [SW-1:0] r_e;
    logic signed [GW-1:0] r_g;

    // tap pipe: read -> multiply -> accumulate / write back
    logic                 r_b_vld;
    logic [TAP_AW-1:0]    r_b_k;
    logic                 r_b_hok;
    logic                 r_c_vld;
    logic [TAP_AW-1:0]    r_c_k;
    logic signed [CW-1:0] r_c_coef;
    logic signed [PRW-1:0] r_prod;

    // output register
    logic                 r_out_vld;
    logic signed [SW-1:0] r_out_data;

    logic                   accept;
    logic                   issue;
    logic [TW-1:0]          taps_sat;
    logic [PW-1:0]          dly_sat;
    logic [PW-1:0]          dist0;
    logic [PW-1:0]          base_diff;
    logic [PW-1:0]          base_pos;
    logic [HIST_W-1:0]      n_pos;
    logic signed [CW-1:0]   mul_a;
    logic signed [SW-1:0]   mul_b;
    logic signed [PRW-1:0]  mul_p;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [ACC_W-1:0] acc_shf;
    logic signed [SW-1:0]   y_sat;
    logic signed [SW:0]     e_diff;
    logic signed [SW-1:0]   e_sat;
    logic signed [PRW-1:0]  upd_rnd;
    logic signed [PRW-1:0]  upd_delta;
    logic signed [CW:0]     coef_sum;
    logic signed [CW-1:0]   coef_new;
    logic                   coef_we;
    logic [TAP_AW-1:0]      coef_wa;
    logic signed [CW-1:0]   coef_wd;

    assign o_stall         = (r_state != S_IDLE);
    assign accept          = i_valid && !o_stall;
    assign o_valid         = r_out_vld;
    assign o_result_sample = r_out_data;
    assign o_cfg_ready     = 1'b1;

    assign issue = ((r_state == S_MAC) || (r_state == S_UPD)) && (r_k < r_taps);

    // window setup at accept: tap count, delay and start of the window
    always_comb begin
        taps_sat  = (TW'(r_order) > C_TAPS_MAX) ? C_TAPS_MAX : TW'(r_order);
        dly_sat   = (PW'(r_delay) >= C_DLY_LIM) ? C_DLY_MAX : PW'(r_delay);
        dist0     = dly_sat + PW'(1);
        base_diff = PW'(r_wi) - dist0;
        base_pos  = base_diff[PW-1] ? (base_diff + C_HIST_LEN) : base_diff;
        n_pos     = (r_pos == '0) ? C_HIST_LAST : (r_pos - HIST_W'(1));
    end

    // shared multiplier
    always_comb begin
        if (r_state == S_GAIN) begin
            mul_a = CW'($signed({1'b0, r_step}));
            mul_b = r_e;
        end else begin
            mul_a = r_upd ? r_g : r_coef_rd;
            mul_b = r_b_hok ? r_hist_rd : '0;
        end
        mul_p = PRW'(mul_a) * PRW'(mul_b);
    end

    // prediction, error and coefficient update arithmetic
    always_comb begin
        acc_rnd = r_acc + C_ACC_HALF;
        acc_shf = acc_rnd >>> lms_ale_pkg::COEF_FRAC;
        if (acc_shf > C_ACC_MAX) begin
            y_sat = SW'(C_ACC_MAX);
        end else if (acc_shf < C_ACC_MIN) begin
            y_sat = SW'(C_ACC_MIN);
        end else begin
            y_sat = acc_shf[SW-1:0];
        end

        e_diff = (SW + 1)'(r_x) - (SW + 1)'(r_y);
        if (e_diff > C_E_MAX) begin
            e_sat = SW'(C_E_MAX);
        end else if (e_diff < C_E_MIN) begin
            e_sat = SW'(C_E_MIN);
        end else begin
            e_sat = e_diff[SW-1:0];
        end

        upd_rnd   = r_prod + C_UPD_HALF;
        upd_delta = upd_rnd >>> lms_ale_pkg::UPD_SHIFT;
        coef_sum  = (CW + 1)'(r_c_coef) + upd_delta[CW:0];
        if (coef_sum > C_COEF_MAX) begin
            coef_new = CW'(C_COEF_MAX);
        end else if (coef_sum < C_COEF_MIN) begin
            coef_new = CW'(C_COEF_MIN);
        end else begin
            coef_new = coef_sum[CW-1:0];
        end

        coef_we = 1'b0;
        coef_wa = r_c_k;
        coef_wd = coef_new;
        if (r_state == S_CLEAR) begin
            coef_we = 1'b1;
            coef_wa = r_clr;
            coef_wd = '0;
        end else if (r_c_vld && r_upd) begin
            coef_we = 1'b1;
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem_hist[r_wi] <= i_sample;
        end
        r_hist_rd <= mem_hist[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            mem_coef[coef_wa] <= coef_wd;
        end
        r_coef_rd <= mem_coef[r_k[TAP_AW-1:0]];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= lms_ale_pkg::ORDER_RST;
            r_delay <= lms_ale_pkg::DELAY_RST;
            r_step  <= lms_ale_pkg::STEP_RST;
            r_mode  <= lms_ale_pkg::MODE_PREDICT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lms_ale_pkg::REG_ORDER: r_order <= i_cfg_data[OW-1:0];
                lms_ale_pkg::REG_DELAY: r_delay <= i_cfg_data[DW-1:0];
                lms_ale_pkg::REG_STEP:  r_step  <= i_cfg_data[lms_ale_pkg::STEP_W-1:0];
                lms_ale_pkg::REG_MODE:  r_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // tap pipe payload
    always_ff @(posedge i_clk) begin
        r_b_k    <= r_k[TAP_AW-1:0];
        r_b_hok  <= (r_dist <= PW'(r_fill));
        r_c_k    <= r_b_k;
        r_c_coef <= r_coef_rd;
        r_prod   <= mul_p;
    end

    // sequencer, per-sample state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_wi      <= '0;
            r_fill    <= '0;
            r_k       <= '0;
            r_upd     <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_b_vld <= issue;
            r_c_vld <= r_b_vld;

            if (r_c_vld && !r_upd) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end

            if (issue) begin
                r_k    <= r_k + TAP_CW'(1);
                r_pos  <= n_pos;
                r_dist <= r_dist + PW'(1);
            end

            // S_OUT reloads the output register itself
            if (r_out_vld && !i_stall && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + TAP_AW'(1);
                    if (r_clr == C_TAP_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_x     <= i_sample;
                        r_taps  <= taps_sat[TAP_CW-1:0];
                        r_base  <= base_pos[HIST_W-1:0];
                        r_pos   <= base_pos[HIST_W-1:0];
                        r_dist0 <= dist0;
                        r_dist  <= dist0;
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_upd   <= 1'b0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (!issue) begin
                        r_state <= S_MAC_WAIT;
                    end
                end
                S_MAC_WAIT: begin
                    if (!r_b_vld && !r_c_vld) begin
                        r_state <= S_PRED;
                    end
                end
                S_PRED: begin
                    r_y     <= y_sat;
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_e     <= e_sat;
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_state <= S_GAIN_LD;
                end
                S_GAIN_LD: begin
                    r_g     <= r_prod[GW-1:0];
                    r_upd   <= 1'b1;
                    r_k     <= '0;
                    r_pos   <= r_base;
                    r_dist  <= r_dist0;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (!issue) begin
                        r_state <= S_UPD_WAIT;
                    end
                end
                S_UPD_WAIT: begin
                    if (!r_b_vld && !r_c_vld) begin
                        r_wi    <= (r_wi == C_HIST_LAST) ? '0 : (r_wi + HIST_W'(1));
                        r_fill  <= (r_fill == C_HIST_LAST) ? r_fill : (r_fill + HIST_W'(1));
                        r_upd   <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_vld || !i_stall) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= (r_mode == lms_ale_pkg::MODE_ERROR) ? r_e : r_y;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the LMS adaptive line enhancer.
// Holds an internal tap/history predictor with a scoreboard of expected output samples.
// Depends on lms_ale_pkg and lms_adaptive_line_enhancer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W   = lms_ale_pkg::SAMPLE_W;
    localparam int COEF_W     = lms_ale_pkg::COEF_W;
    localparam int STEP_W     = lms_ale_pkg::STEP_W;
    localparam int ORDER_W    = lms_ale_pkg::ORDER_W;
    localparam int DELAY_W    = lms_ale_pkg::DELAY_W;
    localparam int COEF_FRAC  = lms_ale_pkg::COEF_FRAC;
    localparam int UPD_SHIFT  = lms_ale_pkg::UPD_SHIFT;
    localparam int CFG_IDX_W  = lms_ale_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = lms_ale_pkg::CFG_DATA_W;

    localparam int MAX_TAPS     = 256;
    localparam int MAX_DELAY    = 256;
    localparam int HIST_DEPTH   = MAX_TAPS + MAX_DELAY;
    // the slowest sample runs the full tap count on both passes, leave some margin
    localparam int END_WAIT     = 2 * MAX_TAPS + 100;
    localparam int SETTLE       = 16;
    localparam int HOLD_CYCLES  = 1500;
    localparam int CYCLE_LIMIT  = 5_000_000;

    // Scoreboard: bit-exact predictor of the filter plus the queue of expected outputs.
    class line_enhancer_scoreboard;
        logic [ORDER_W-1:0]         order;
        logic [DELAY_W-1:0]         dly;
        logic [STEP_W-1:0]          step;
        logic                       mode;
        logic signed [SAMPLE_W-1:0] history [HIST_DEPTH];
        logic signed [COEF_W-1:0]   coef [MAX_TAPS];
        int unsigned                wr_idx;
        logic signed [SAMPLE_W-1:0] expected_outputs [$];
        int unsigned                samples_seen;
        int unsigned                results_checked;
        int unsigned                failures;

        function new();
            order = lms_ale_pkg::ORDER_RST;
            dly   = lms_ale_pkg::DELAY_RST;
            step  = lms_ale_pkg::STEP_RST;
            mode  = lms_ale_pkg::MODE_PREDICT;
            foreach (history[i]) history[i] = '0;
            foreach (coef[i]) coef[i] = '0;
            wr_idx = 0;
            samples_seen = 0;
            results_checked = 0;
            failures = 0;
        endfunction

        static function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // add half an LSB, then floor (arithmetic shift)
        static function longint round_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                lms_ale_pkg::REG_ORDER: order = data[ORDER_W-1:0];
                lms_ale_pkg::REG_DELAY: dly   = data[DELAY_W-1:0];
                lms_ale_pkg::REG_STEP:  step  = data[STEP_W-1:0];
                lms_ale_pkg::REG_MODE:  mode  = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned tap_pos(int unsigned lag_dly, int unsigned k);
            return (wr_idx + HIST_DEPTH - ((lag_dly + 1 + k) % HIST_DEPTH)) % HIST_DEPTH;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] x);
            int unsigned taps, lag_dly, k;
            longint      acc, y, e, g, delta;
            taps    = (order > MAX_TAPS) ? MAX_TAPS : order;
            lag_dly = (dly >= MAX_DELAY) ? MAX_DELAY - 1 : dly;
            history[wr_idx] = x;
            acc = 0;
            for (k = 0; k < taps; k++)
                acc += longint'(coef[k]) * longint'(history[tap_pos(lag_dly, k)]);
            y = clamp(round_shift(acc, COEF_FRAC), -32768, 32767);
            e = clamp(longint'(x) - y, -32768, 32767);
            g = longint'(step) * e;
            for (k = 0; k < taps; k++) begin
                delta = round_shift(g * longint'(history[tap_pos(lag_dly, k)]), UPD_SHIFT);
                coef[k] = COEF_W'(clamp(longint'(coef[k]) + delta,
                                        -64'sd2147483648, 64'sd2147483647));
            end
            wr_idx = (wr_idx + 1) % HIST_DEPTH;
            expected_outputs.push_back((mode == lms_ale_pkg::MODE_ERROR) ?
                                       e[SAMPLE_W-1:0] : y[SAMPLE_W-1:0]);
            samples_seen++;
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (expected_outputs.size() == 0) begin
                $error("result_sample: unexpected output, actual %0d", got);
                failures++;
                return;
            end
            want = expected_outputs.pop_front();
            results_checked++;
            if (got !== want) begin
                $error("result_sample: expected %0d, actual %0d", want, got);
                failures++;
            end
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        function void check_drained();
            if (expected_outputs.size() != 0) begin
                $error("result_sample: %0d expected outputs never arrived",
                       expected_outputs.size());
                failures++;
            end
        endfunction
    endclass

    // DUT ports, all driven to known values from time zero
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample    = '0;
    logic                       o_valid;
    logic                       i_stall     = 1'b0;
    logic signed [SAMPLE_W-1:0] o_result_sample;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data  = '0;

    lms_adaptive_line_enhancer #(
        .MAX_TAPS  (MAX_TAPS),
        .MAX_DELAY (MAX_DELAY)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_sample (o_result_sample),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    line_enhancer_scoreboard ale = new();

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle knobs, percent per cycle. The main flow changes them between phases.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned settings_applied = 0;

    // Long receiver hold-off. Counted in its own process, updated on posedge so the
    // stall driver (negedge) always sees a settled value.
    event stall_burst;
    logic hold_active = 1'b0;

    initial begin
        forever begin
            @(stall_burst);
            @(posedge i_clk);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active = 1'b0;
        end
    end

    // Receiver stall: random per cycle, forced high during a hold-off.
    always @(negedge i_clk) begin
        i_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
    end

    // Output monitor: one transaction per edge with o_valid high and i_stall low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            ale.check_result(o_result_sample);
    end

    // Watchdog on a free-running cycle count.
    int unsigned cycle_count = 0;
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d outputs outstanding", cycle_count, ale.pending());
        $display("Test completed with failures");
        $finish;
    end

    // Offer one sample; entered and left at a falling edge. Valid is left high after
    // the transaction so back-to-back samples never drop it for a step.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= x;
        do @(posedge i_clk); while (o_stall);
        ale.note_sample(x);
        @(negedge i_clk);
    endtask

    // One register write transaction; caller drops i_cfg_valid after the batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        ale.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Write all four registers. Bits above each register width are random, and
    // sometimes an index past the register map is poked as well.
    task automatic apply_config(input int unsigned ord, input int unsigned dly,
                                input int unsigned stp, input int unsigned md);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[ORDER_W-1:0] = ord[ORDER_W-1:0];
        write_reg(lms_ale_pkg::REG_ORDER, d);
        d = CFG_DATA_W'($urandom);
        d[DELAY_W-1:0] = dly[DELAY_W-1:0];
        write_reg(lms_ale_pkg::REG_DELAY, d);
        write_reg(lms_ale_pkg::REG_STEP, stp[STEP_W-1:0]);
        d = CFG_DATA_W'($urandom);
        d[0] = md[0];
        write_reg(lms_ale_pkg::REG_MODE, d);
        if ($urandom_range(3) == 0)
            write_reg(CFG_IDX_W'(lms_ale_pkg::REG_MODE + 1 + $urandom_range(3)),
                      CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Sender pause: drop valid, let the scoreboard empty, then let the clock run idle so
    // the datapath is quiet before any register write.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (ale.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic random_config(input bit wide_order);
        int unsigned ord, dly, stp, r;
        r = $urandom_range(99);
        if (wide_order)  ord = $urandom_range(511, 256);
        else if (r < 2)  ord = 0;
        else if (r < 70) ord = $urandom_range(16, 1);
        else if (r < 90) ord = $urandom_range(64, 17);
        else             ord = $urandom_range(128, 65);
        dly = ($urandom_range(99) < 60) ? $urandom_range(4) : $urandom_range(255);
        r = $urandom_range(9);
        if (r == 0)      stp = 0;
        else if (r == 1) stp = 65535;
        else if (r < 6)  stp = $urandom_range(4096);
        else             stp = $urandom_range(65535);
        apply_config(ord, dly, stp, $urandom_range(1));
    endtask

    // Stimulus generator. Mostly periodic bursts (a random waveform repeated with
    // light noise) so the taps actually converge; the rest is wideband noise
    // with full-scale hits.
    int          tone [48];
    int unsigned tone_len   = 1;
    int unsigned tone_pos   = 0;
    int unsigned burst_left = 0;
    int unsigned noise_amp  = 0;
    bit          noise_only = 1'b0;

    function automatic logic signed [SAMPLE_W-1:0] next_sample();
        int amp, v;
        if (burst_left == 0) begin
            burst_left = $urandom_range(120, 20);
            noise_only = ($urandom_range(99) < 30);
            tone_len   = $urandom_range(48, 2);
            tone_pos   = 0;
            amp        = $urandom_range(32767, 1);
            noise_amp  = $urandom_range(2000);
            for (int i = 0; i < tone_len; i++)
                tone[i] = int'($urandom_range(2 * amp)) - amp;
        end
        burst_left--;
        if (noise_only) begin
            case ($urandom_range(9))
                0:       return 16'sh7fff;
                1:       return 16'sh8000;
                default: return SAMPLE_W'($urandom);
            endcase
        end
        v = tone[tone_pos % tone_len] + int'($urandom_range(2 * noise_amp)) - int'(noise_amp);
        tone_pos++;
        if (v > 32767)  v = 32767;
        if (v < -32768) v = -32768;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic run_phase(input int unsigned count, input int unsigned idle_pct,
                             input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int unsigned i = 0; i < count; i++) begin
            // now and then the sender waits for every output before going on
            if ($urandom_range(59) == 0) wait_for_results();
            send_sample(next_sample());
        end
    endtask

    // idle profiles cycled through the random phases: none, sender, receiver, both
    int unsigned idle_tab  [4] = '{0, 72, 0, 35};
    int unsigned stall_tab [4] = '{0, 0, 72, 35};

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset registers (16 taps, delay 1, small step, prediction out),
        // full-scale and alternating-bit samples. The first one also waits out
        // the coefficient clear sweep.
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(16'shffff);
        send_sample(16'sh5555);
        send_sample(16'shaaaa);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);

        // no taps: prediction is zero, the error is the sample itself
        wait_for_results();
        apply_config(0, 0, 65535, lms_ale_pkg::MODE_ERROR);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh3039);

        // order beyond the tap count saturates; longest delay, largest step
        wait_for_results();
        apply_config(511, 255, 65535, lms_ale_pkg::MODE_PREDICT);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);

        // single tap, no delay, max step on a constant full-scale input:
        // the tap climbs fast and drives output and tap saturation
        wait_for_results();
        apply_config(1, 0, 65535, lms_ale_pkg::MODE_ERROR);
        repeat (3) send_sample(16'sh7fff);
        repeat (3) send_sample(16'sh8000);

        // Pressure: hold the output off for a long stretch while samples keep
        // coming, so the output register fills and o_stall backs up the input.
        wait_for_results();
        apply_config(16, 1, 2000, lms_ale_pkg::MODE_PREDICT);
        -> stall_burst;
        run_phase(8, 0, 0);

        // Random phases across many register settings and idle profiles.
        for (int unsigned seg = 0; seg < 12; seg++) begin
            wait_for_results();
            random_config(1'b0);
            run_phase(90, idle_tab[seg % 4], stall_tab[seg % 4]);
        end

        // a few samples at the full tap count
        wait_for_results();
        random_config(1'b1);
        run_phase(40, idle_tab[3], stall_tab[3]);

        i_valid <= 1'b0;
        wait_for_results();
        repeat (END_WAIT) @(negedge i_clk);
        ale.check_drained();

        $display("Sent %0d samples and checked %0d outputs over %0d register settings,",
                 ale.samples_seen, ale.results_checked, settings_applied);
        $display("with both output modes, tap counts 0 to 256 and four idle profiles.");
        if (ale.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
